FILE: design/bsmt_pkg.sv
// ----------------------------------------------------------------------------
// Backing store map table package
// Shared field widths, action codes and sequencer states for the backing
// store map table.
// ----------------------------------------------------------------------------
package bsmt_pkg;

  localparam int ACT_W      = 3;
  localparam int PROC_W     = 6;
  localparam int STORE_W    = 4;
  localparam int PAGE_W     = 20;
  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 9;
  localparam int PAGE_SHIFT = 12;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR_ALL = 3'd0,
    ACT_FIND_FREE = 3'd1,
    ACT_FREE      = 3'd2,
    ACT_LOOKUP    = 3'd3,
    ACT_MAP       = 3'd4,
    ACT_UNMAP     = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_MODIFY,
    ST_DONE
  } state_e;

endpackage

FILE: design/bsmt_store_mem.sv
// ----------------------------------------------------------------------------
// Backing store entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsmt_store_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 71
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bsmt_match_unit.sv
// ----------------------------------------------------------------------------
// Backing store match unit
// Tests one entry per cycle: free for find free, or owned by the process at
// or below the page for lookup and unmap, and forms the page offset.
// ----------------------------------------------------------------------------
module bsmt_match_unit
  import bsmt_pkg::*;
#(
  parameter int NUM_PROCS = 50
) (
  input  logic                 find_free_i,
  input  logic                 ent_vld_i,
  input  logic [NUM_PROCS-1:0] ent_owner_i,
  input  logic [PAGE_W-1:0]    ent_base_i,
  input  logic [PROC_W-1:0]    proc_id_i,
  input  logic [PAGE_W-1:0]    page_i,
  output logic                 hit_o,
  output logic [PAGE_W-1:0]    offset_o
);

  logic [63:0] owner_ext;
  logic        owned;

  // The owner bitmap is widened so that any process number indexes it.
  assign owner_ext = 64'(ent_owner_i);
  assign owned     = ent_vld_i && owner_ext[proc_id_i] && (page_i >= ent_base_i);
  assign hit_o     = find_free_i ? !ent_vld_i : owned;
  assign offset_o  = page_i - ent_base_i;

endmodule

FILE: design/backing_store_map_table_top.sv
// ----------------------------------------------------------------------------
// Backing store map table
// Table of backing store entries with clear, find free, free, lookup, map and
// unmap actions, run one at a time by a small sequencer over one entry memory.
// ----------------------------------------------------------------------------
// Usage
// An action enters on the input channel (in_valid_i / in_stall_o) and exactly
// one result leaves on the output channel (out_valid_o / out_stall_i). A
// transfer takes place on a rising edge where valid is high and stall is low.
// The block works on one action at a time and holds in_stall_o high from the
// transfer until the result has been placed in the output register.
// Clear all, free and every rejected action finish in the decode state, map
// reads and then rewrites its entry, and find free, lookup and unmap scan
// the entries in order up to the first match, or through all of them when
// nothing matches. The scan reads one entry per cycle from the single read
// port of the entry memory.
// The output register decouples the two channels: a new action is taken
// while an earlier result still waits under out_stall_i, and a finished
// action waits in the sequencer until that register is free.
// Reset clears the mapped flags, which act as entry valid bits, so the
// table is empty at once and no clearing pass is needed.
// ----------------------------------------------------------------------------
module backing_store_map_table_top
  import bsmt_pkg::*;
#(
  parameter int NUM_STORES = 16,
  parameter int NUM_PROCS  = 50,
  parameter int MAX_PAGES  = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ACT_W-1:0]   action_i,
  input  logic [PROC_W-1:0]  proc_id_i,
  input  logic [STORE_W-1:0] store_sel_i,
  input  logic [PAGE_W-1:0]  virt_page_i,
  input  logic [ADDR_W-1:0]  virt_addr_i,
  input  logic [COUNT_W-1:0] page_count_i,
  input  logic               private_flag_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic [STORE_W-1:0] store_found_o,
  output logic [PAGE_W-1:0]  page_offset_o
);

  localparam int SW = (NUM_STORES > 1) ? $clog2(NUM_STORES) : 1;
  localparam int CW = $clog2(NUM_STORES + 1);
  localparam int EW = NUM_PROCS + PAGE_W + 1;

  // Sequencer state and captured action.
  state_e              state_q, state_d;
  action_e             act_q;
  logic [PROC_W-1:0]   pid_q;
  logic [SW-1:0]       sel_q;
  logic [PAGE_W-1:0]   page_q;
  logic                priv_q;
  logic                pid_ok_q;
  logic                sel_ok_q;
  logic                cnt_ok_q;

  // Entry valid bits: an entry that is not mapped reads as all zero.
  logic [NUM_STORES-1:0] mapped_q, mapped_d;

  // Scan bookkeeping: read counter and the entry being checked.
  logic [CW-1:0] rd_cnt_q, rd_cnt_d;
  logic          chk_vld_q, chk_vld_d;
  logic [SW-1:0] chk_idx_q, chk_idx_d;

  // Pending result and the output register.
  logic               res_status_q, res_status_d;
  logic [STORE_W-1:0] res_store_q, res_store_d;
  logic [PAGE_W-1:0]  res_offset_q, res_offset_d;
  logic               out_valid_q, out_valid_d;
  logic               out_status_q;
  logic [STORE_W-1:0] out_store_q;
  logic [PAGE_W-1:0]  out_offset_q;
  logic               out_load;

  // Memory ports.
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [SW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  // Entry under test and match unit results.
  logic                 ent_vld;
  logic [NUM_PROCS-1:0] ent_owner;
  logic [PAGE_W-1:0]    ent_base;
  logic                 ent_priv;
  logic [NUM_PROCS-1:0] pid_mask;
  logic                 hit;
  logic [PAGE_W-1:0]    offset;
  logic                 in_xfer;
  logic                 rd_more;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Capture the action. The lookup page comes from the byte address; map and
  // unmap take the virtual page directly.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q    <= action_e'(action_i);
      pid_q    <= proc_id_i;
      sel_q    <= SW'(store_sel_i);
      priv_q   <= private_flag_i;
      pid_ok_q <= (32'(proc_id_i) < NUM_PROCS);
      sel_ok_q <= (32'(store_sel_i) < NUM_STORES);
      cnt_ok_q <= (page_count_i != '0) && (32'(page_count_i) <= MAX_PAGES);
      if (action_e'(action_i) == ACT_LOOKUP) begin
        page_q <= virt_addr_i[ADDR_W-1:PAGE_SHIFT];
      end else begin
        page_q <= virt_page_i;
      end
    end
  end

  bsmt_store_mem #(
    .DEPTH (NUM_STORES),
    .WIDTH (EW)
  ) u_store_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Whenever an entry is checked or modified, the read data belongs to the entry at chk_idx_q.
  assign ent_vld   = mapped_q[chk_idx_q];
  assign ent_owner = ent_vld ? mem_rdata[NUM_PROCS-1:0] : '0;
  assign ent_base  = ent_vld ? mem_rdata[NUM_PROCS +: PAGE_W] : '0;
  assign ent_priv  = ent_vld && mem_rdata[EW-1];
  assign pid_mask  = NUM_PROCS'(64'd1 << pid_q);

  bsmt_match_unit #(
    .NUM_PROCS (NUM_PROCS)
  ) u_match_unit (
    .find_free_i (act_q == ACT_FIND_FREE),
    .ent_vld_i   (ent_vld),
    .ent_owner_i (ent_owner),
    .ent_base_i  (ent_base),
    .proc_id_i   (pid_q),
    .page_i      (page_q),
    .hit_o       (hit),
    .offset_o    (offset)
  );

  assign rd_more = (rd_cnt_q < CW'(NUM_STORES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mapped_q    <= '0;
      out_valid_q <= 1'b0;
      chk_vld_q   <= 1'b0;
      rd_cnt_q    <= '0;
    end else begin
      state_q     <= state_d;
      mapped_q    <= mapped_d;
      out_valid_q <= out_valid_d;
      chk_vld_q   <= chk_vld_d;
      rd_cnt_q    <= rd_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q    <= chk_idx_d;
    res_status_q <= res_status_d;
    res_store_q  <= res_store_d;
    res_offset_q <= res_offset_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_store_q  <= res_store_q;
      out_offset_q <= res_offset_q;
    end
  end

  // Sequencer: decode, scan or read-modify-write, then hand the result over.
  always_comb begin
    state_d      = state_q;
    mapped_d     = mapped_q;
    rd_cnt_d     = rd_cnt_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    res_status_d = res_status_q;
    res_store_d  = res_store_q;
    res_offset_d = res_offset_q;
    mem_we       = 1'b0;
    mem_waddr    = chk_idx_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = sel_q;
    out_load     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_START;
        end
      end

      ST_START: begin
        // An error with empty result fields unless an action says otherwise.
        res_status_d = 1'b1;
        res_store_d  = '0;
        res_offset_d = '0;
        rd_cnt_d     = '0;
        state_d      = ST_DONE;
        case (act_q)
          ACT_CLEAR_ALL: begin
            mapped_d     = '0;
            res_status_d = 1'b0;
          end
          ACT_FIND_FREE: begin
            state_d = ST_SCAN;
          end
          ACT_LOOKUP, ACT_UNMAP: begin
            if (pid_ok_q) begin
              state_d = ST_SCAN;
            end
          end
          ACT_FREE: begin
            if (sel_ok_q) begin
              mapped_d[sel_q] = 1'b0;
              res_status_d    = 1'b0;
            end
          end
          ACT_MAP: begin
            if (pid_ok_q && sel_ok_q && cnt_ok_q) begin
              mem_re    = 1'b1;
              mem_raddr = sel_q;
              chk_idx_d = sel_q;
              state_d   = ST_MODIFY;
            end
          end
          default: begin
          end
        endcase
      end

      ST_SCAN: begin
        // Issue the next read while the previous entry is checked.
        mem_re    = rd_more;
        mem_raddr = rd_cnt_q[SW-1:0];
        if (rd_more) begin
          rd_cnt_d  = rd_cnt_q + CW'(1);
          chk_vld_d = 1'b1;
          chk_idx_d = rd_cnt_q[SW-1:0];
        end
        if (chk_vld_q && hit) begin
          chk_vld_d    = 1'b0;
          chk_idx_d    = chk_idx_q;
          res_status_d = 1'b0;
          state_d      = ST_DONE;
          case (act_q)
            ACT_FIND_FREE: begin
              res_store_d = STORE_W'(chk_idx_q);
            end
            ACT_LOOKUP: begin
              res_store_d  = STORE_W'(chk_idx_q);
              res_offset_d = offset;
            end
            default: begin
              // Unmap: a private heap frees the whole store, otherwise only
              // the owner bit of the process is dropped.
              if (ent_priv) begin
                mapped_d[chk_idx_q] = 1'b0;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = chk_idx_q;
                mem_wdata = {ent_priv, ent_base, ent_owner & ~pid_mask};
              end
            end
          endcase
        end else if (!rd_more) begin
          state_d = ST_DONE;
        end
      end

      ST_MODIFY: begin
        mem_we              = 1'b1;
        mem_waddr           = chk_idx_q;
        mem_wdata           = {priv_q, page_q, ent_owner | pid_mask};
        mapped_d[chk_idx_q] = 1'b1;
        res_status_d        = 1'b0;
        state_d             = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d   = out_load || (out_valid_q && out_stall_i);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign store_found_o = out_store_q;
  assign page_offset_o = out_offset_q;

endmodule

FILE: sim/backing_store_map_table_checker.sv
// ----------------------------------------------------------------------------
// Backing store map table checker
// Watches both channels of the map table. It keeps its own copy of the
// store entries, works out the result of every accepted action and compares
// each result transfer, field by field, with the oldest outstanding result.
// ----------------------------------------------------------------------------
module backing_store_map_table_checker
  import bsmt_pkg::*;
#(
  parameter int NUM_STORES = 16,
  parameter int NUM_PROCS  = 50,
  parameter int MAX_PAGES  = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [ACT_W-1:0]   action_i,
  input  logic [PROC_W-1:0]  proc_id_i,
  input  logic [STORE_W-1:0] store_sel_i,
  input  logic [PAGE_W-1:0]  virt_page_i,
  input  logic [ADDR_W-1:0]  virt_addr_i,
  input  logic [COUNT_W-1:0] page_count_i,
  input  logic               private_flag_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               status_i,
  input  logic [STORE_W-1:0] store_found_i,
  input  logic [PAGE_W-1:0]  page_offset_i,
  output int                 fail_count_o,
  output int                 outstanding_o
);

  typedef struct packed {
    logic               status;
    logic [STORE_W-1:0] store_found;
    logic [PAGE_W-1:0]  page_offset;
  } table_result_t;

  // Shadow copy of the store entries.
  logic                 mapped_q [NUM_STORES];
  logic [NUM_PROCS-1:0] owners_q [NUM_STORES];
  logic [PAGE_W-1:0]    base_q   [NUM_STORES];
  logic [COUNT_W-1:0]   pages_q  [NUM_STORES];
  logic                 priv_q   [NUM_STORES];
  logic [5:0]           maps_q   [NUM_STORES];

  table_result_t expected_results [$];
  table_result_t got_r;
  table_result_t want_r;
  int            fails;

  function automatic void clear_store(input int s);
    mapped_q[s] = 1'b0;
    owners_q[s] = '0;
    base_q[s]   = '0;
    pages_q[s]  = '0;
    priv_q[s]   = 1'b0;
    maps_q[s]   = '0;
  endfunction

  // Lowest store owned by the process whose base page is at or below the page.
  function automatic bit find_owned_store(input int pid, input logic [PAGE_W-1:0] page,
                                          output int st);
    st = 0;
    for (int s = 0; s < NUM_STORES; s++) begin
      if (owners_q[s][pid] && page >= base_q[s]) begin
        st = s;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic table_result_t apply_table_action(
    input logic [ACT_W-1:0]   act,
    input logic [PROC_W-1:0]  pid,
    input logic [STORE_W-1:0] sel,
    input logic [PAGE_W-1:0]  vpage,
    input logic [ADDR_W-1:0]  vaddr,
    input logic [COUNT_W-1:0] npages,
    input logic               priv
  );
    table_result_t     r;
    int                st;
    bit                pid_ok;
    bit                sel_ok;
    logic [PAGE_W-1:0] page;
    r        = '0;
    r.status = 1'b1;
    pid_ok   = int'(pid) < NUM_PROCS;
    sel_ok   = int'(sel) < NUM_STORES;
    page     = vaddr[ADDR_W-1:PAGE_SHIFT];
    case (act)
      ACT_CLEAR_ALL: begin
        for (int s = 0; s < NUM_STORES; s++) clear_store(s);
        r.status = 1'b0;
      end
      ACT_FIND_FREE: begin
        // Walk downwards so that the lowest free store is the one kept.
        for (int s = NUM_STORES - 1; s >= 0; s--) begin
          if (!mapped_q[s]) begin
            r.status      = 1'b0;
            r.store_found = STORE_W'(s);
          end
        end
      end
      ACT_FREE: begin
        if (sel_ok) begin
          clear_store(int'(sel));
          r.status = 1'b0;
        end
      end
      ACT_LOOKUP: begin
        if (pid_ok && find_owned_store(int'(pid), page, st)) begin
          r.status      = 1'b0;
          r.store_found = STORE_W'(st);
          r.page_offset = page - base_q[st];
        end
      end
      ACT_MAP: begin
        if (pid_ok && sel_ok && npages != 0 && int'(npages) <= MAX_PAGES) begin
          mapped_q[sel]      = 1'b1;
          owners_q[sel][pid] = 1'b1;
          base_q[sel]        = vpage;
          pages_q[sel]       = npages;
          priv_q[sel]        = priv;
          maps_q[sel]        = maps_q[sel] + 6'd1;
          r.status           = 1'b0;
        end
      end
      ACT_UNMAP: begin
        if (pid_ok && find_owned_store(int'(pid), vpage, st) && mapped_q[st]) begin
          if (priv_q[st]) clear_store(st);
          else owners_q[st][pid] = 1'b0;
          r.status = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_STORES; s++) clear_store(s);
      expected_results.delete();
      fails = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got_r = '{status_i, store_found_i, page_offset_i};
        if (expected_results.size() == 0) begin
          $error("result transfer with no result outstanding");
          fails++;
        end else begin
          want_r = expected_results.pop_front();
          if (got_r.status !== want_r.status) begin
            $error("status: expected %0d, got %0d", want_r.status, got_r.status);
            fails++;
          end
          if (got_r.store_found !== want_r.store_found) begin
            $error("store_found: expected %0d, got %0d",
                   want_r.store_found, got_r.store_found);
            fails++;
          end
          if (got_r.page_offset !== want_r.page_offset) begin
            $error("page_offset: expected 0x%05h, got 0x%05h",
                   want_r.page_offset, got_r.page_offset);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(apply_table_action(action_i, proc_id_i, store_sel_i,
                                                      virt_page_i, virt_addr_i,
                                                      page_count_i, private_flag_i));
      end
      fail_count_o  <= fails;
      outstanding_o <= expected_results.size();
    end
  end

endmodule

FILE: sim/backing_store_map_table_top_tb.sv
// ----------------------------------------------------------------------------
// Backing store map table testbench
// Drives directed and then random table actions into the map table, with
// random gaps and stalls on both channels, and leaves all checking to the
// checker that sits beside the block. Gives the verdict at the end.
// ----------------------------------------------------------------------------
module backing_store_map_table_top_tb;
  import bsmt_pkg::*;

  localparam int NUM_STORES = 16;
  localparam int NUM_PROCS  = 50;
  localparam int MAX_PAGES  = 256;

  // The two action codes that the package leaves undefined.
  localparam logic [ACT_W-1:0] ACT_UNDEF_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNDEF_HI = 3'd7;

  localparam int RANDOM_ITEMS = 1125;
  // Random transfer at which the sender waits until the table has answered all.
  localparam int DRAIN_AT     = 350;
  // Number of transfers after which the receiver holds off for a long stretch.
  localparam int HOLD_AFTER   = 300;
  localparam int LONG_HOLD    = 80;
  localparam int QUIET_TAIL   = 150;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [ACT_W-1:0]   action_i;
  logic [PROC_W-1:0]  proc_id_i;
  logic [STORE_W-1:0] store_sel_i;
  logic [PAGE_W-1:0]  virt_page_i;
  logic [ADDR_W-1:0]  virt_addr_i;
  logic [COUNT_W-1:0] page_count_i;
  logic               private_flag_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               status_o;
  logic [STORE_W-1:0] store_found_o;
  logic [PAGE_W-1:0]  page_offset_o;

  int mismatch_count;
  int results_pending;
  int sent_cnt;
  // Random gaps and stall bursts on either side are only allowed while this is set.
  bit idle_en;

  backing_store_map_table_top #(
    .NUM_STORES(NUM_STORES),
    .NUM_PROCS (NUM_PROCS),
    .MAX_PAGES (MAX_PAGES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .proc_id_i     (proc_id_i),
    .store_sel_i   (store_sel_i),
    .virt_page_i   (virt_page_i),
    .virt_addr_i   (virt_addr_i),
    .page_count_i  (page_count_i),
    .private_flag_i(private_flag_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .store_found_o (store_found_o),
    .page_offset_o (page_offset_o)
  );

  backing_store_map_table_checker #(
    .NUM_STORES(NUM_STORES),
    .NUM_PROCS (NUM_PROCS),
    .MAX_PAGES (MAX_PAGES)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .action_i      (action_i),
    .proc_id_i     (proc_id_i),
    .store_sel_i   (store_sel_i),
    .virt_page_i   (virt_page_i),
    .virt_addr_i   (virt_addr_i),
    .page_count_i  (page_count_i),
    .private_flag_i(private_flag_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status_o),
    .store_found_i (store_found_o),
    .page_offset_i (page_offset_o),
    .fail_count_o  (mismatch_count),
    .outstanding_o (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard limit on the run. It lies above the slowest correct run, which has
  // the longest scan, longest gap and longest stall on every transfer, plus
  // the long hold-off.
  initial begin
    #1_000_000;
    $display("backing_store_map_table_top_tb: errors");
    $finish;
  end

  // Offers one action and returns once the block has taken the transfer. A
  // random gap may come first, during which valid is low; valid is otherwise
  // left high from one transfer to the next.
  task automatic offer_action(input logic [ACT_W-1:0]   act,
                              input logic [PROC_W-1:0]  pid,
                              input logic [STORE_W-1:0] sel,
                              input logic [PAGE_W-1:0]  vpage,
                              input logic [ADDR_W-1:0]  vaddr,
                              input logic [COUNT_W-1:0] npages,
                              input logic               priv);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    proc_id_i      <= pid;
    store_sel_i    <= sel;
    virt_page_i    <= vpage;
    virt_addr_i    <= vaddr;
    page_count_i   <= npages;
    private_flag_i <= priv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_cnt++;
  endtask

  // Receiver: random stall bursts while idling is allowed, and once a long
  // hold-off so that the output register and the sequencer both fill up and
  // the block has to stall its input while the sender keeps offering.
  initial begin : receiver
    int burst;
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && sent_cnt >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 6);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : sender
    int                 slot;
    int                 pick;
    bit                 noise;
    logic [PROC_W-1:0]  pid;
    logic [STORE_W-1:0] sel;
    logic [PAGE_W-1:0]  page;
    logic [COUNT_W-1:0] npages;
    logic [PROC_W-1:0]  recent_pid  [8];
    logic [PAGE_W-1:0]  recent_base [8];

    sent_cnt = 0;
    idle_en  = 1'b1;
    for (int k = 0; k < 8; k++) begin
      recent_pid[k]  = PROC_W'(k);
      recent_base[k] = '0;
    end

    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    action_i       <= ACT_CLEAR_ALL;
    proc_id_i      <= '0;
    store_sel_i    <= '0;
    virt_page_i    <= '0;
    virt_addr_i    <= '0;
    page_count_i   <= '0;
    private_flag_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The table starts empty, so the first find free must
    // give store zero and the first lookup must fail.
    offer_action(ACT_CLEAR_ALL, 6'd0, 4'd0, 20'h0, 32'h0, 9'd0, 1'b0);
    offer_action(ACT_FIND_FREE, 6'd0, 4'd0, 20'h0, 32'h0, 9'd0, 1'b0);
    offer_action(ACT_LOOKUP, 6'd0, 4'd0, 20'h0, 32'h0, 9'd0, 1'b0);
    // Smallest and largest legal maps: one page at the bottom, and a
    // private store of the maximum size at the very top of the page range.
    offer_action(ACT_MAP, 6'd0, 4'd0, 20'h0, 32'h0, 9'd1, 1'b0);
    offer_action(ACT_MAP, 6'd49, 4'd15, 20'hFFFFF, 32'h0, 9'd256, 1'b1);
    offer_action(ACT_LOOKUP, 6'd49, 4'd0, 20'h0, 32'hFFFF_FFFF, 9'd0, 1'b0);
    // Far beyond the one mapped page: there is no upper bound check, so
    // this still hits store zero with the largest offset.
    offer_action(ACT_LOOKUP, 6'd0, 4'd0, 20'h0, 32'hFFFF_F000, 9'd0, 1'b0);
    // Process numbers at and beyond the process count are refused.
    offer_action(ACT_LOOKUP, 6'd50, 4'd0, 20'h0, 32'h0000_5000, 9'd0, 1'b0);
    offer_action(ACT_MAP, 6'd63, 4'd1, 20'h0, 32'h0, 9'd1, 1'b0);
    // Page counts of zero and above the maximum are refused.
    offer_action(ACT_MAP, 6'd2, 4'd1, 20'h0, 32'h0, 9'd0, 1'b0);
    offer_action(ACT_MAP, 6'd2, 4'd1, 20'h0, 32'h0, 9'd257, 1'b0);
    offer_action(ACT_MAP, 6'd2, 4'd1, 20'h0, 32'h0, 9'd511, 1'b0);
    offer_action(ACT_FIND_FREE, 6'd0, 4'd0, 20'h0, 32'h0, 9'd0, 1'b0);
    // A second process maps the same store; its base page moves up, so the
    // first owner no longer finds it below that base.
    offer_action(ACT_MAP, 6'd1, 4'd0, 20'h0000A, 32'h0, 9'd4, 1'b0);
    offer_action(ACT_LOOKUP, 6'd0, 4'd0, 20'h0, 32'h0000_5000, 9'd0, 1'b0);
    // Unmap of a shared store only drops the owner bit.
    offer_action(ACT_UNMAP, 6'd0, 4'd0, 20'h00014, 32'h0, 9'd0, 1'b0);
    offer_action(ACT_LOOKUP, 6'd0, 4'd0, 20'h0, 32'h0001_4000, 9'd0, 1'b0);
    // Unmap of a private store frees it entirely.
    offer_action(ACT_UNMAP, 6'd49, 4'd0, 20'hFFFFF, 32'h0, 9'd0, 1'b0);
    offer_action(ACT_LOOKUP, 6'd49, 4'd0, 20'h0, 32'hFFFF_FFFF, 9'd0, 1'b0);
    // Unmap below the base page finds nothing.
    offer_action(ACT_UNMAP, 6'd1, 4'd0, 20'h00003, 32'h0, 9'd0, 1'b0);
    offer_action(ACT_FREE, 6'd0, 4'd0, 20'h0, 32'h0, 9'd0, 1'b0);
    offer_action(ACT_UNDEF_LO, 6'd0, 4'd0, 20'h0, 32'h0, 9'd0, 1'b0);
    offer_action(ACT_UNDEF_HI, 6'd63, 4'd15, 20'hFFFFF, 32'hFFFF_FFFF, 9'd511, 1'b1);
    offer_action(ACT_FREE, 6'd0, 4'd15, 20'h0, 32'h0, 9'd0, 1'b0);
    offer_action(ACT_FIND_FREE, 6'd0, 4'd0, 20'h0, 32'h0, 9'd0, 1'b0);

    // Random part. Most lookups and unmaps reuse a process and base page
    // from a recent map, so that they hit live stores; about one in ten
    // actions carries raw random fields instead, which may be out of range.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Idling comes in windows, with a clean window every fourth hundred
      // transfers and none at all over the final stretch.
      idle_en = (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / 100) % 4 != 3);
      if (i == DRAIN_AT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (results_pending != 0) @(posedge clk_i);
      end
      slot  = $urandom_range(0, 7);
      noise = ($urandom_range(0, 9) == 0);
      pid   = noise ? PROC_W'($urandom) : recent_pid[slot];
      page  = recent_base[slot] + PAGE_W'($urandom_range(0, 300));
      sel   = STORE_W'($urandom_range(0, NUM_STORES - 1));
      pick  = $urandom_range(0, 99);
      if (pick < 28) begin
        if (!noise) pid = PROC_W'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
          0, 1:    page = PAGE_W'($urandom_range(0, 1023));
          2:       page = PAGE_W'($urandom);
          default: page = 20'hFFF00 + PAGE_W'($urandom_range(0, 255));
        endcase
        npages = noise ? COUNT_W'($urandom) : COUNT_W'($urandom_range(1, MAX_PAGES));
        offer_action(ACT_MAP, pid, sel, page, $urandom, npages, 1'($urandom_range(0, 1)));
        recent_pid[slot]  = pid;
        recent_base[slot] = page;
      end else if (pick < 58) begin
        // Now and then ask just below the base page, where the recent map does not match.
        if ($urandom_range(0, 6) == 0) page = recent_base[slot] - PAGE_W'($urandom_range(1, 64));
        offer_action(ACT_LOOKUP, pid, sel, PAGE_W'($urandom), {page, 12'($urandom)},
                     COUNT_W'($urandom), 1'($urandom_range(0, 1)));
      end else if (pick < 73) begin
        if ($urandom_range(0, 6) == 0) page = PAGE_W'($urandom);
        offer_action(ACT_UNMAP, pid, sel, page, $urandom, COUNT_W'($urandom),
                     1'($urandom_range(0, 1)));
      end else if (pick < 83) begin
        offer_action(ACT_FIND_FREE, pid, sel, page, $urandom, COUNT_W'($urandom),
                     1'($urandom_range(0, 1)));
      end else if (pick < 93) begin
        offer_action(ACT_FREE, pid, sel, page, $urandom, COUNT_W'($urandom),
                     1'($urandom_range(0, 1)));
      end else if (pick < 96) begin
        offer_action(ACT_CLEAR_ALL, pid, sel, page, $urandom, COUNT_W'($urandom),
                     1'($urandom_range(0, 1)));
      end else begin
        // Any action code at all, the undefined ones included, with raw fields.
        offer_action(ACT_W'($urandom), PROC_W'($urandom), STORE_W'($urandom),
                     PAGE_W'($urandom), $urandom, COUNT_W'($urandom),
                     1'($urandom_range(0, 1)));
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    // Allow for a longest scan in case anything stray is still on its way.
    repeat (NUM_STORES + 8) @(posedge clk_i);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("backing_store_map_table_top_tb: clean");
    end else begin
      $display("backing_store_map_table_top_tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/bsmt_pkg.sv
design/bsmt_store_mem.sv
design/bsmt_match_unit.sv
design/backing_store_map_table_top.sv
sim/backing_store_map_table_checker.sv
sim/backing_store_map_table_top_tb.sv
